// ----- rtl/core/oems_pkg.sv -----
package oems_pkg;

  localparam int DEF_MAX_ITEMS = 64;
  localparam int VALUE_W       = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } set_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_out;
  } run_item_t;

  typedef struct packed {
    logic start;
    logic adv;
  } sched_ctrl_t;

  typedef struct packed {
    logic done;
    logic hit;
  } sched_stat_t;

endpackage

// ----- rtl/core/odd_even_merge_sorter.sv -----
// channel  signals                          direction  payload
// set      set_valid set_stall set_item     in         value, last
// run      run_valid run_stall run_item     out        sorted_value, last_out
//
// Loading accepts one item per cycle; set_stall is high from the closing item
// until the sort is done and the last result is in the output register.
// Sort: each comparator passes SCAN (read), CMP (compare) and, on a swap, WR2,
// the single RAM write port taking both writes; out-of-set steps skip CMP.
// Emit: FETCH (RAM read), then EMIT (output register); run_stall holds EMIT.
// rst is synchronous and clears count, state and the output valid.
module odd_even_merge_sorter
  import oems_pkg::*;
#(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      set_valid,
  output logic      set_stall,
  input  set_item_t set_item,
  output logic      run_valid,
  input  logic      run_stall,
  output run_item_t run_item
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_CMP   = 6'b000100,
    ST_WR2   = 6'b001000,
    ST_FETCH = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] eidx, eidx_next;
  logic [VALUE_W-1:0] hi_val;

  sched_ctrl_t   sctrl;
  sched_stat_t   sstat;
  logic [AW-1:0] addr_a, addr_b;

  logic               we;
  logic [AW-1:0]      waddr, raddr_a;
  logic [VALUE_W-1:0] wdata, rd_a, rd_b;

  logic accept, swap, load_out, emit_last;

  assign set_stall = state != ST_LOAD;
  assign accept    = set_valid && !set_stall;
  assign swap      = $signed(rd_a) > $signed(rd_b);
  assign load_out  = (state == ST_EMIT) && (!run_valid || !run_stall);
  assign emit_last = (eidx + CW'(1)) == count;
  assign raddr_a   = ((state == ST_FETCH) || (state == ST_EMIT)) ? eidx[AW-1:0] : addr_a;

  oems_sched #(.MAX_ITEMS(MAX_ITEMS)) u_sched (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (sctrl),
    .count  (count),
    .stat   (sstat),
    .addr_a (addr_a),
    .addr_b (addr_b)
  );

  // mirrored stores give two read ports
  oems_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_ram_a (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rd_a)
  );

  oems_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_ram_b (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr_b),
    .rdata (rd_b)
  );

  always_comb begin
    state_next = state;
    count_next = count;
    eidx_next  = eidx;
    sctrl      = '0;
    we         = 1'b0;
    waddr      = addr_a;
    wdata      = rd_b;
    case (state)
      ST_LOAD: begin
        waddr = count[AW-1:0];
        wdata = set_item.value;
        if (accept) begin
          if (count < CW'(MAX_ITEMS)) begin
            we         = 1'b1;
            count_next = count + CW'(1);
          end
          if (set_item.last) begin
            sctrl.start = 1'b1;
            state_next  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (sstat.done) begin
          eidx_next  = '0;
          state_next = ST_FETCH;
        end else if (sstat.hit) begin
          state_next = ST_CMP;
        end else begin
          sctrl.adv = 1'b1;
        end
      end
      ST_CMP: begin
        if (swap) begin
          we         = 1'b1;
          state_next = ST_WR2;
        end else begin
          sctrl.adv  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_WR2: begin
        we         = 1'b1;
        waddr      = addr_b;
        wdata      = hi_val;
        sctrl.adv  = 1'b1;
        state_next = ST_SCAN;
      end
      ST_FETCH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (load_out) begin
          eidx_next = eidx + CW'(1);
          if (emit_last) begin
            count_next = '0;
            state_next = ST_LOAD;
          end else begin
            state_next = ST_FETCH;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      eidx      <= '0;
      run_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      eidx  <= eidx_next;
      if (load_out) begin
        run_valid <= 1'b1;
      end else if (!run_stall) begin
        run_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CMP) begin
      hi_val <= rd_a;
    end
    if (load_out) begin
      run_item <= '{sorted_value: $signed(rd_a), last_out: emit_last};
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("element count beyond store depth");

  a_cmp_in_set: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (CW'(addr_b) < count && addr_a < addr_b))
    else $error("comparator outside set or misordered");

  a_wr2_after_cmp: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR2) |-> ($past(state) == ST_CMP && $past(swap)))
    else $error("second write without a swap");

  a_emit_in_set: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (eidx < count))
    else $error("emit index beyond set");

endmodule

// ----- rtl/core/oems_ram.sv -----
module oems_ram
  import oems_pkg::*;
#(
  parameter int WIDTH = VALUE_W,
  parameter int DEPTH = DEF_MAX_ITEMS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/oems_sched.sv -----
module oems_sched
  import oems_pkg::*;
#(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS,
  localparam int AW = $clog2(MAX_ITEMS),
  localparam int CW = $clog2(MAX_ITEMS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  sched_ctrl_t   ctrl,
  input  logic [CW-1:0] count,
  output sched_stat_t   stat,
  output logic [AW-1:0] addr_a,
  output logic [AW-1:0] addr_b
);

  // pass p, stride k, group base j, offset i
  localparam int SW = CW + 2;

  logic [SW-1:0] p, k, j, i;
  logic [SW-1:0] p_next, k_next, j_next, i_next;
  logic [SW-1:0] n, a, b, mask;
  logic          live;

  assign n    = SW'(count);
  assign a    = i + j;
  assign b    = a + k;
  assign mask = ~((p << 1) - SW'(1));
  assign live = (j + k) < n;

  assign stat.done = p >= n;
  assign stat.hit  = live && ((a & mask) == (b & mask));
  assign addr_a    = a[AW-1:0];
  assign addr_b    = b[AW-1:0];

  always_comb begin
    p_next = p;
    k_next = k;
    j_next = j;
    i_next = i;
    if (ctrl.start) begin
      p_next = SW'(1);
      k_next = SW'(1);
      j_next = '0;
      i_next = '0;
    end else if (ctrl.adv) begin
      if (live && (i + SW'(1)) < k && (b + SW'(1)) < n) begin
        i_next = i + SW'(1);
      end else if ((j + (k << 1) + k) < n) begin
        j_next = j + (k << 1);
        i_next = '0;
      end else if (k > SW'(1)) begin
        k_next = k >> 1;
        j_next = k >> 1;
        i_next = '0;
      end else begin
        p_next = p << 1;
        k_next = p << 1;
        j_next = '0;
        i_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p <= SW'(1);
      k <= SW'(1);
      j <= '0;
      i <= '0;
    end else begin
      p <= p_next;
      k <= k_next;
      j <= j_next;
      i <= i_next;
    end
  end

endmodule
